### rtl/trpid_pkg.sv
// Shared widths, constants and types for the three-axis rate PID block.
// No dependencies; every other file imports this package.
`default_nettype none

package trpid_pkg;

  // Axes and lanes
  localparam int NUM_AXES = 3;
  localparam int AX_ROLL  = 0;
  localparam int AX_PITCH = 1;
  localparam int AX_YAW   = 2;

  // Port field widths
  localparam int RATE_W  = 20;
  localparam int STICK_W = 12;
  localparam int ANGLE_W = 17;
  localparam int DRIVE_W = 18;
  localparam int ELEV_W  = 20;
  localparam int GAIN_W  = 24;

  // Configuration port
  localparam int NUM_REGS  = 8;
  localparam int REG_W     = 3;
  localparam int CFG_IDX_W = 4;

  // Register indexes
  localparam logic [REG_W-1:0] REG_ROLL_P  = 3'd0;
  localparam logic [REG_W-1:0] REG_ROLL_I  = 3'd1;
  localparam logic [REG_W-1:0] REG_ROLL_D  = 3'd2;
  localparam logic [REG_W-1:0] REG_PITCH_P = 3'd3;
  localparam logic [REG_W-1:0] REG_PITCH_I = 3'd4;
  localparam logic [REG_W-1:0] REG_PITCH_D = 3'd5;
  localparam logic [REG_W-1:0] REG_YAW_P   = 3'd6;
  localparam logic [REG_W-1:0] REG_YAW_I   = 3'd7;

  localparam logic [GAIN_W-1:0] GAIN_RST [NUM_REGS] = '{
    24'd13422, 24'd470, 24'd134218,
    24'd13422, 24'd470, 24'd134218,
    24'd838861, 24'd235
  };

  // Internal datapath widths
  localparam int SP_W  = 24;   // setpoint, signed Q.8
  localparam int ERR_W = 24;   // error, signed Q.8

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // One setpoint request handed from front to back
  typedef struct packed {
    logic [NUM_AXES-1:0][RATE_W-1:0] rate;
    logic [NUM_AXES-1:0][SP_W-1:0]   setp;
    logic [ELEV_W-1:0]               elev;
    logic                            clr;
  } trpid_sp_t;

  // Gain set seen by the PID lanes
  typedef struct packed {
    logic [NUM_AXES-1:0][GAIN_W-1:0] kp;
    logic [NUM_AXES-1:0][GAIN_W-1:0] ki;
    logic [NUM_AXES-1:0][GAIN_W-1:0] kd;
  } trpid_gains_t;

endpackage

`default_nettype wire

### rtl/trpid_if.sv
// Request and response channel interfaces (valid/ready plus payload fields).
// Depends on trpid_pkg for field widths.
`default_nettype none

interface trpid_req_if;
  import trpid_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [RATE_W-1:0]  roll_rate;
  logic signed [RATE_W-1:0]  pitch_rate;
  logic signed [RATE_W-1:0]  yaw_rate;
  logic [STICK_W-1:0]        stick_roll;
  logic [STICK_W-1:0]        stick_pitch;
  logic [STICK_W-1:0]        stick_yaw;
  logic [STICK_W-1:0]        stick_throttle;
  logic signed [ANGLE_W-1:0] roll_angle;
  logic signed [ANGLE_W-1:0] pitch_angle;
  logic                      level_enable;
  logic                      link_up;
  logic                      clear_integrals;

  modport source (
    output valid, roll_rate, pitch_rate, yaw_rate, stick_roll, stick_pitch,
           stick_yaw, stick_throttle, roll_angle, pitch_angle, level_enable,
           link_up, clear_integrals,
    input  ready
  );

  modport sink (
    input  valid, roll_rate, pitch_rate, yaw_rate, stick_roll, stick_pitch,
           stick_yaw, stick_throttle, roll_angle, pitch_angle, level_enable,
           link_up, clear_integrals,
    output ready
  );
endinterface

interface trpid_rsp_if;
  import trpid_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] roll_drive;
  logic signed [DRIVE_W-1:0] pitch_drive;
  logic signed [DRIVE_W-1:0] yaw_drive;
  logic signed [ELEV_W-1:0]  elevation_setpoint;

  modport source (
    output valid, roll_drive, pitch_drive, yaw_drive, elevation_setpoint,
    input  ready
  );

  modport sink (
    input  valid, roll_drive, pitch_drive, yaw_drive, elevation_setpoint,
    output ready
  );
endinterface

`default_nettype wire

### rtl/trpid_front.sv
// Front end: accepts stick/attitude requests and turns them into setpoints.
// Two stages (numerator, reciprocal multiply for /3). Depends on trpid_pkg.
`default_nettype none

module trpid_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  trpid_req_if.sink             req_i,
  output logic                  push_o,
  output trpid_pkg::trpid_sp_t  push_data_o,
  input  wire logic             full_i
);
  import trpid_pkg::*;

  localparam int OFF_W     = 13;
  localparam int NUM_W     = 26;
  localparam int MAG_W     = 25;
  localparam int RECIP_W   = 24;
  localparam int QPROD_W   = MAG_W + RECIP_W;
  localparam int RECIP_SH  = 25;

  localparam logic [RECIP_W-1:0]      RECIP3      = 24'd11184811; // ceil(2^25/3)
  localparam logic signed [OFF_W-1:0] DB_HIGH     = 13'sd1512;
  localparam logic signed [OFF_W-1:0] DB_LOW      = 13'sd1488;
  localparam logic signed [NUM_W-1:0] STICK_SCALE = 26'sd3840;   // 15 * 256
  localparam logic signed [NUM_W-1:0] ANGLE_SCALE = 26'sd7;
  localparam logic signed [NUM_W-1:0] YAW_SCALE   = 26'sd512;
  localparam logic signed [ELEV_W-1:0] ELEV_SCALE = 20'sd128;

  // Stick position relative to the dead band
  function automatic logic signed [OFF_W-1:0] stick_offset(input logic [STICK_W-1:0] s);
    logic signed [OFF_W-1:0] v;
    v = signed'({1'b0, s});
    if (v > DB_HIGH) return v - DB_HIGH;
    else if (v < DB_LOW) return v - DB_LOW;
    else return '0;
  endfunction

  logic fen;
  logic f1_v_q, f2_v_q;

  logic signed [NUM_W-1:0]  num_d [NUM_AXES];
  logic signed [NUM_W-1:0]  f1_num_q [NUM_AXES];
  logic [RATE_W-1:0]        f1_rate_q [NUM_AXES];
  logic signed [ELEV_W-1:0] elev_d, f1_elev_q, f2_elev_q;
  logic                     f1_clr_q, f2_clr_q;

  logic [QPROD_W-1:0]       prod_d [NUM_AXES];
  logic                     neg_d [NUM_AXES];
  logic [QPROD_W-1:0]       f2_prod_q [NUM_AXES];
  logic                     f2_neg_q [NUM_AXES];
  logic [RATE_W-1:0]        f2_rate_q [NUM_AXES];

  logic signed [OFF_W-1:0]  off_r, off_p, off_y, off_t;

  // Both stages advance together unless the queue refuses the head
  assign fen         = !f2_v_q || !full_i;
  assign req_i.ready = fen;
  assign push_o      = f2_v_q && !full_i;

  // Setpoint numerators before the divide by three
  always_comb begin
    off_r = stick_offset(req_i.stick_roll);
    off_p = stick_offset(req_i.stick_pitch);
    off_y = stick_offset(req_i.stick_yaw);
    off_t = stick_offset(req_i.stick_throttle);
    for (int a = 0; a < NUM_AXES; a++) num_d[a] = '0;
    elev_d = '0;
    if (req_i.link_up) begin
      num_d[AX_ROLL]  = NUM_W'(off_r) * STICK_SCALE;
      num_d[AX_PITCH] = -(NUM_W'(off_p) * STICK_SCALE);
      if (req_i.level_enable) begin
        num_d[AX_ROLL]  = num_d[AX_ROLL] - NUM_W'(req_i.roll_angle) * ANGLE_SCALE;
        num_d[AX_PITCH] = num_d[AX_PITCH] - NUM_W'(req_i.pitch_angle) * ANGLE_SCALE;
      end
      num_d[AX_YAW] = NUM_W'(off_y) * YAW_SCALE;
      elev_d        = ELEV_W'(off_t) * ELEV_SCALE;
    end
  end

  // Magnitude times reciprocal of three (exact for magnitudes below 2^25)
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      neg_d[a]  = f1_num_q[a][NUM_W-1];
      prod_d[a] = QPROD_W'(MAG_W'(neg_d[a] ? -f1_num_q[a] : f1_num_q[a]))
                * QPROD_W'(RECIP3);
    end
  end

  // Quotient with the sign restored (truncates toward zero)
  always_comb begin
    push_data_o.elev = f2_elev_q;
    push_data_o.clr  = f2_clr_q;
    for (int a = 0; a < NUM_AXES; a++) begin
      push_data_o.rate[a] = f2_rate_q[a];
      push_data_o.setp[a] = f2_neg_q[a] ? -SP_W'(f2_prod_q[a] >> RECIP_SH)
                                        :  SP_W'(f2_prod_q[a] >> RECIP_SH);
    end
  end

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
      f2_v_q <= 1'b0;
    end else if (fen) begin
      f1_v_q <= req_i.valid;
      f2_v_q <= f1_v_q;
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (fen && req_i.valid) begin
      f1_num_q             <= num_d;
      f1_rate_q[AX_ROLL]   <= req_i.roll_rate;
      f1_rate_q[AX_PITCH]  <= req_i.pitch_rate;
      f1_rate_q[AX_YAW]    <= req_i.yaw_rate;
      f1_elev_q            <= elev_d;
      f1_clr_q             <= req_i.clear_integrals;
    end
    if (fen && f1_v_q) begin
      f2_prod_q <= prod_d;
      f2_neg_q  <= neg_d;
      f2_rate_q <= f1_rate_q;
      f2_elev_q <= f1_elev_q;
      f2_clr_q  <= f1_clr_q;
    end
  end

endmodule

`default_nettype wire

### rtl/trpid_queue.sv
// Two-entry request queue between the setpoint front end and the PID back end.
// Depends on trpid_pkg for the entry type.
`default_nettype none

module trpid_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire trpid_pkg::trpid_sp_t push_data_i,
  output logic                  full_o,
  output logic                  valid_o,
  output trpid_pkg::trpid_sp_t  data_o,
  input  wire logic             pop_i
);
  import trpid_pkg::*;

  trpid_sp_t          mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]  cnt_q;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

`default_nettype wire

### rtl/trpid_back.sv
// Back end: per-axis PID lanes with integral and drive clamping.
// Six-stage pipeline ending in the response register. Depends on trpid_pkg.
`default_nettype none

module trpid_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               q_valid_i,
  input  wire trpid_pkg::trpid_sp_t    q_data_i,
  output logic                    pop_o,
  input  wire trpid_pkg::trpid_gains_t gains_i,
  trpid_rsp_if.source             rsp_o
);
  import trpid_pkg::*;

  localparam int DIFF_W  = ERR_W + 1;
  localparam int KG_W    = GAIN_W + 1;
  localparam int PROD_W  = KG_W + ERR_W;
  localparam int DPROD_W = KG_W + DIFF_W;
  localparam int PDIV_W  = PROD_W - 8;
  localparam int INT_W   = 34;
  localparam int ITMP_W  = PDIV_W + 1;
  localparam int SUM_W   = DPROD_W + 2;
  localparam int SDIV_W  = SUM_W - 24;

  localparam logic signed [PROD_W-1:0] PI_BIAS   = 49'sd255;
  localparam logic signed [SUM_W-1:0]  SUM_BIAS  = 52'sd16777215;
  localparam logic signed [INT_W-1:0]  INT_LIM   = 34'sd6710886400; // 400 << 24
  localparam logic signed [SDIV_W-1:0] DRIVE_LIM = 28'sd102400;     // 400 << 8

  logic ben;
  logic b1_v_q, b2_v_q, b3_v_q, b4_v_q, b5_v_q, out_v_q;

  // Lane state
  logic signed [ERR_W-1:0]   last_err_q [NUM_AXES];
  logic signed [INT_W-1:0]   int_q [NUM_AXES];

  // Stage data
  logic signed [ERR_W-1:0]   err_d [NUM_AXES];
  logic signed [DIFF_W-1:0]  diff_d [NUM_AXES];
  logic signed [ERR_W-1:0]   b1_err_q [NUM_AXES];
  logic signed [DIFF_W-1:0]  b1_diff_q [NUM_AXES];

  logic signed [PROD_W-1:0]  pp_d [NUM_AXES];
  logic signed [PROD_W-1:0]  pi_d [NUM_AXES];
  logic signed [DPROD_W-1:0] pd_d [NUM_AXES];
  logic signed [PROD_W-1:0]  b2_pp_q [NUM_AXES];
  logic signed [PROD_W-1:0]  b2_pi_q [NUM_AXES];
  logic signed [DPROD_W-1:0] b2_pd_q [NUM_AXES];

  logic signed [PDIV_W-1:0]  pdiv_d [NUM_AXES];
  logic signed [PDIV_W-1:0]  b3_pdiv_q [NUM_AXES];
  logic signed [PROD_W-1:0]  b3_pp_q [NUM_AXES];
  logic signed [DPROD_W-1:0] b3_pd_q [NUM_AXES];

  logic signed [INT_W-1:0]   int_d [NUM_AXES];
  logic signed [INT_W-1:0]   b4_int_q [NUM_AXES];
  logic signed [PROD_W-1:0]  b4_pp_q [NUM_AXES];
  logic signed [DPROD_W-1:0] b4_pd_q [NUM_AXES];

  logic signed [SUM_W-1:0]   sum_d [NUM_AXES];
  logic signed [SUM_W-1:0]   b5_sum_q [NUM_AXES];

  logic signed [DRIVE_W-1:0] drive_d [NUM_AXES];
  logic signed [DRIVE_W-1:0] drive_q [NUM_AXES];

  logic [ELEV_W-1:0] b1_elev_q, b2_elev_q, b3_elev_q, b4_elev_q, b5_elev_q, elev_q;
  logic              b1_clr_q, b2_clr_q, b3_clr_q;

  // Whole pipeline holds while the response register is stalled
  assign ben   = !out_v_q || rsp_o.ready;
  assign pop_o = q_valid_i && ben;

  assign rsp_o.valid              = out_v_q;
  assign rsp_o.roll_drive         = drive_q[AX_ROLL];
  assign rsp_o.pitch_drive        = drive_q[AX_PITCH];
  assign rsp_o.yaw_drive          = drive_q[AX_YAW];
  assign rsp_o.elevation_setpoint = signed'(elev_q);

  // Error and error change
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      err_d[a]  = ERR_W'(DIFF_W'(signed'(q_data_i.rate[a])) - DIFF_W'(signed'(q_data_i.setp[a])));
      diff_d[a] = DIFF_W'(err_d[a]) - DIFF_W'(last_err_q[a]);
    end
  end

  // Gain products
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      pp_d[a] = PROD_W'(signed'({1'b0, gains_i.kp[a]})) * PROD_W'(b1_err_q[a]);
      pi_d[a] = PROD_W'(signed'({1'b0, gains_i.ki[a]})) * PROD_W'(b1_err_q[a]);
      pd_d[a] = DPROD_W'(signed'({1'b0, gains_i.kd[a]})) * DPROD_W'(b1_diff_q[a]);
    end
  end

  // Integral increment: drop 8 fraction bits toward zero
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      pdiv_d[a] = PDIV_W'((b2_pi_q[a] + (b2_pi_q[a][PROD_W-1] ? PI_BIAS : '0)) >>> 8);
    end
  end

  // Integral update with optional clear and clamp
  always_comb begin
    logic signed [ITMP_W-1:0] itmp;
    for (int a = 0; a < NUM_AXES; a++) begin
      itmp = ITMP_W'(b3_pdiv_q[a]);
      if (!b3_clr_q) itmp = itmp + ITMP_W'(int_q[a]);
      if (itmp > ITMP_W'(INT_LIM)) int_d[a] = INT_LIM;
      else if (itmp <= -ITMP_W'(INT_LIM)) int_d[a] = -INT_LIM;
      else int_d[a] = INT_W'(itmp);
    end
  end

  // Drive sum with 32 fraction bits
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      sum_d[a] = SUM_W'(b4_pp_q[a]) + (SUM_W'(b4_int_q[a]) <<< 8) + SUM_W'(b4_pd_q[a]);
    end
  end

  // Back to Q.8 toward zero, then clamp
  always_comb begin
    logic signed [SDIV_W-1:0] sq;
    for (int a = 0; a < NUM_AXES; a++) begin
      sq = SDIV_W'((b5_sum_q[a] + (b5_sum_q[a][SUM_W-1] ? SUM_BIAS : '0)) >>> 24);
      if (sq > DRIVE_LIM) drive_d[a] = DRIVE_W'(DRIVE_LIM);
      else if (sq < -DRIVE_LIM) drive_d[a] = DRIVE_W'(-DRIVE_LIM);
      else drive_d[a] = DRIVE_W'(sq);
    end
  end

  // Stage valids and lane state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q  <= 1'b0;
      b2_v_q  <= 1'b0;
      b3_v_q  <= 1'b0;
      b4_v_q  <= 1'b0;
      b5_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      for (int a = 0; a < NUM_AXES; a++) begin
        last_err_q[a] <= '0;
        int_q[a]      <= '0;
      end
    end else if (ben) begin
      b1_v_q  <= q_valid_i;
      b2_v_q  <= b1_v_q;
      b3_v_q  <= b2_v_q;
      b4_v_q  <= b3_v_q;
      b5_v_q  <= b4_v_q;
      out_v_q <= b5_v_q;
      if (q_valid_i) last_err_q <= err_d;
      if (b3_v_q)    int_q      <= int_d;
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (ben) begin
      if (q_valid_i) begin
        b1_err_q  <= err_d;
        b1_diff_q <= diff_d;
        b1_elev_q <= q_data_i.elev;
        b1_clr_q  <= q_data_i.clr;
      end
      if (b1_v_q) begin
        b2_pp_q   <= pp_d;
        b2_pi_q   <= pi_d;
        b2_pd_q   <= pd_d;
        b2_elev_q <= b1_elev_q;
        b2_clr_q  <= b1_clr_q;
      end
      if (b2_v_q) begin
        b3_pdiv_q <= pdiv_d;
        b3_pp_q   <= b2_pp_q;
        b3_pd_q   <= b2_pd_q;
        b3_elev_q <= b2_elev_q;
        b3_clr_q  <= b2_clr_q;
      end
      if (b3_v_q) begin
        b4_int_q  <= int_d;
        b4_pp_q   <= b3_pp_q;
        b4_pd_q   <= b3_pd_q;
        b4_elev_q <= b3_elev_q;
      end
      if (b4_v_q) begin
        b5_sum_q  <= sum_d;
        b5_elev_q <= b4_elev_q;
      end
      if (b5_v_q) begin
        drive_q <= drive_d;
        elev_q  <= b5_elev_q;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/three_axis_rate_pid_top.sv
// Path: a request passes 2 setpoint stages, the queue entry register and 5 PID stages
// feeding the output register before its response is valid.
// Throughput: one request per cycle unless the response stalls; the integral feedback
// is a single add-and-clamp stage, and a stalled response holds the PID pipeline while
// the 2-entry queue absorbs the front end. Reset clears integrals, previous errors,
// valids and restores default gains at once; no clearing pass is needed.
`default_nettype none

module three_axis_rate_pid_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  trpid_req_if.sink                              req_i,
  trpid_rsp_if.source                            rsp_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [trpid_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [trpid_pkg::GAIN_W-1:0]      cfg_data_i
);
  import trpid_pkg::*;

  logic [GAIN_W-1:0] gain_q [NUM_REGS];
  trpid_gains_t      gains;

  logic      push, full, q_valid, pop;
  trpid_sp_t push_data, q_data;

  // Gain registers; writes past the last index are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_RST;
    end else if (cfg_we_i && (cfg_idx_i < CFG_IDX_W'(NUM_REGS))) begin
      gain_q[cfg_idx_i[REG_W-1:0]] <= cfg_data_i;
    end
  end

  // Gain set per lane; yaw has no derivative term
  always_comb begin
    gains.kp[AX_ROLL]  = gain_q[REG_ROLL_P];
    gains.ki[AX_ROLL]  = gain_q[REG_ROLL_I];
    gains.kd[AX_ROLL]  = gain_q[REG_ROLL_D];
    gains.kp[AX_PITCH] = gain_q[REG_PITCH_P];
    gains.ki[AX_PITCH] = gain_q[REG_PITCH_I];
    gains.kd[AX_PITCH] = gain_q[REG_PITCH_D];
    gains.kp[AX_YAW]   = gain_q[REG_YAW_P];
    gains.ki[AX_YAW]   = gain_q[REG_YAW_I];
    gains.kd[AX_YAW]   = '0;
  end

  trpid_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  trpid_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .valid_o     (q_valid),
    .data_o      (q_data),
    .pop_i       (pop)
  );

  trpid_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (q_data),
    .pop_o     (pop),
    .gains_i   (gains),
    .rsp_o     (rsp_o)
  );

endmodule

`default_nettype wire
